// File: rtl/core/rmq_pkg.sv
// ---------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Item formats, work item passed from front to back, and fixed widths.
// ---------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = DATA_WIDTH - 2;
  localparam int LIMIT_WIDTH = 14;
  // radicand term t = 1 + diagonal combination, below 7 * 2^F
  localparam int T_WIDTH     = FRAC_BITS + 3;
  // sum or difference of two elements
  localparam int NUM_WIDTH   = DATA_WIDTH + 1;
  localparam int ROOT_WIDTH  = FRAC_BITS + 2;
  // magnitude of an unnormalized component, up to 2 * 2^F - 1
  localparam int COMP_WIDTH  = FRAC_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    TIED_W,
    TIED_X,
    TIED_Y,
    TIED_Z
  } tied_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
  } out_item_t;

  // numerators in component order with the tied slot skipped
  typedef struct packed {
    tied_t                       tied;
    logic [T_WIDTH-1:0]          t;
    logic signed [NUM_WIDTH-1:0] num0;
    logic signed [NUM_WIDTH-1:0] num1;
    logic signed [NUM_WIDTH-1:0] num2;
  } work_t;

endpackage

`default_nettype wire

// File: rtl/core/rmq_delay.sv
// ---------------------------------------------------------------------------
// rmq_delay: side payload delay line
// Carries item data alongside an arithmetic unit of matching latency.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[N-1];

endmodule

`default_nettype wire

// File: rtl/core/rmq_isqrt.sv
// ---------------------------------------------------------------------------
// rmq_isqrt: pipelined floor square root
// One root bit per stage, remainder kept as radicand minus root squared.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_isqrt #(
  parameter int NW = 8,
  localparam int RB = (NW + 1) / 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rad,
  output logic [RB-1:0] root
);

  localparam int WW = 2 * RB + 1;

  logic [WW-1:0] rem_r  [RB];
  logic [RB-1:0] root_r [RB];

  for (genvar i = 0; i < RB; i++) begin : g_stage
    localparam int K = RB - 1 - i;
    logic [WW-1:0] rem_in;
    logic [WW-1:0] trial;
    logic [RB-1:0] root_in;

    if (i == 0) begin : g_first
      assign rem_in  = WW'(rad);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // (r + 2^k)^2 - r^2
    assign trial = ((WW'(root_in) << 1) + (WW'(1) << K)) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[i]  <= rem_in - trial;
          root_r[i] <= root_in | (RB'(1) << K);
        end else begin
          rem_r[i]  <= rem_in;
          root_r[i] <= root_in;
        end
      end
    end
  end

  assign root = root_r[RB-1];

endmodule

`default_nettype wire

// File: rtl/core/rmq_div.sv
// ---------------------------------------------------------------------------
// rmq_div: pipelined saturating unsigned divider
// Overflow check stage, then one restoring quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_div #(
  parameter int NW  = 8,
  parameter int DNW = 8,
  parameter int K   = 4
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic [K-1:0]   quo
);

  localparam int WW = ((NW > DNW + K) ? NW : DNW + K) + 1;

  logic [WW-1:0]  rem_r [K+1];
  logic [DNW-1:0] den_r [K+1];
  logic [K-1:0]   quo_r [K+1];
  logic           sat_r [K+1];

  // quotient would not fit in K bits (also taken for a zero divisor)
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= WW'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      sat_r[0] <= WW'(num) >= (WW'(den) << K);
    end
  end

  for (genvar i = 0; i < K; i++) begin : g_stage
    localparam int B = K - 1 - i;
    logic [WW-1:0] trial;

    assign trial = WW'(den_r[i]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i+1] <= den_r[i];
        sat_r[i+1] <= sat_r[i];
        if (rem_r[i] >= trial) begin
          rem_r[i+1] <= rem_r[i] - trial;
          quo_r[i+1] <= quo_r[i] | (K'(1) << B);
        end else begin
          rem_r[i+1] <= rem_r[i];
          quo_r[i+1] <= quo_r[i];
        end
      end
    end
  end

  assign quo = sat_r[K] ? '1 : quo_r[K];

endmodule

`default_nettype wire

// File: rtl/core/rmq_front.sv
// ---------------------------------------------------------------------------
// rmq_front: matrix intake and branch selection
// Picks the trace or diagonal branch, forms t and the three numerators.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_front import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     wk_valid,
  input  logic     wk_ready,
  output work_t    wk_item
);

  localparam int TS = DATA_WIDTH + 3;

  logic                      wk_valid_r;
  work_t                     wk_r;
  work_t                     wk_nxt;
  logic signed [TS-1:0]      one_q;
  logic signed [TS-1:0]      e00, e11, e22;
  logic signed [TS-1:0]      trace;
  logic signed [TS-1:0]      t_full;
  logic signed [NUM_WIDTH-1:0] d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;

  always_comb begin
    one_q  = TS'(1) <<< FRAC_BITS;
    e00    = TS'(in_item.m00);
    e11    = TS'(in_item.m11);
    e22    = TS'(in_item.m22);
    trace  = e00 + e11 + e22;
    d21m12 = NUM_WIDTH'(in_item.m21) - NUM_WIDTH'(in_item.m12);
    d02m20 = NUM_WIDTH'(in_item.m02) - NUM_WIDTH'(in_item.m20);
    d10m01 = NUM_WIDTH'(in_item.m10) - NUM_WIDTH'(in_item.m01);
    s10p01 = NUM_WIDTH'(in_item.m10) + NUM_WIDTH'(in_item.m01);
    s02p20 = NUM_WIDTH'(in_item.m02) + NUM_WIDTH'(in_item.m20);
    s21p12 = NUM_WIDTH'(in_item.m21) + NUM_WIDTH'(in_item.m12);
    wk_nxt = '0;
    if (trace > 0) begin
      wk_nxt.tied = TIED_W;
      t_full      = trace + one_q;
      wk_nxt.num0 = d21m12;
      wk_nxt.num1 = d02m20;
      wk_nxt.num2 = d10m01;
    end else if (in_item.m00 > in_item.m11 && in_item.m00 > in_item.m22) begin
      wk_nxt.tied = TIED_X;
      t_full      = one_q + e00 - e11 - e22;
      wk_nxt.num0 = d21m12;
      wk_nxt.num1 = s10p01;
      wk_nxt.num2 = s02p20;
    end else if (in_item.m11 > in_item.m22) begin
      wk_nxt.tied = TIED_Y;
      t_full      = one_q + e11 - e00 - e22;
      wk_nxt.num0 = d02m20;
      wk_nxt.num1 = s10p01;
      wk_nxt.num2 = s21p12;
    end else begin
      wk_nxt.tied = TIED_Z;
      t_full      = one_q + e22 - e00 - e11;
      wk_nxt.num0 = d10m01;
      wk_nxt.num1 = s02p20;
      wk_nxt.num2 = s21p12;
    end
    // a negative radicand only comes from a matrix that is no rotation
    wk_nxt.t = t_full[TS-1] ? '0 : T_WIDTH'(t_full);
  end

  assign in_ready = !wk_valid_r || wk_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_valid_r <= 1'b0;
    end else if (in_ready) begin
      wk_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      wk_r <= wk_nxt;
    end
  end

  assign wk_valid = wk_valid_r;
  assign wk_item  = wk_r;

endmodule

`default_nettype wire

// File: rtl/core/rmq_fifo.sv
// ---------------------------------------------------------------------------
// rmq_fifo: work item queue
// Short queue between the front and the arithmetic back end.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_fifo import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  s_valid,
  output logic  s_ready,
  input  work_t s_item,
  output logic  m_valid,
  input  logic  m_ready,
  output work_t m_item
);

  logic [QPTR_WIDTH-1:0] wr_ptr_r;
  logic [QPTR_WIDTH-1:0] rd_ptr_r;
  logic [QPTR_WIDTH:0]   count_r;
  logic [QPTR_WIDTH:0]   count_nxt;
  work_t                 slot_r [QUEUE_DEPTH];
  logic                  push;
  logic                  pop;

  assign s_ready = count_r != (QPTR_WIDTH+1)'(QUEUE_DEPTH);
  assign m_valid = count_r != '0;
  assign m_item  = slot_r[rd_ptr_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= s_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rmq_back.sv
// ---------------------------------------------------------------------------
// rmq_back: quaternion arithmetic pipeline
// Root, component divides, square and sum, magnitude root, normalize divides, output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_back import rmq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wk_valid,
  output logic                   wk_ready,
  input  work_t                  wk_item,
  input  logic [LIMIT_WIDTH-1:0] limit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item
);

  localparam int F    = FRAC_BITS;
  localparam int RW   = ROOT_WIDTH;
  localparam int CW   = COMP_WIDTH;
  localparam int NW1  = NUM_WIDTH + F;
  localparam int K1   = CW;
  localparam int SW   = 2 * F + 4;
  localparam int NW2  = CW + F;
  localparam int K2   = DATA_WIDTH;
  localparam int LAT  = RW + (K1 + 1) + 2 + RW + (K2 + 1);
  localparam int LW   = RW + LIMIT_WIDTH;

  typedef struct packed {
    tied_t          tied;
    logic [2:0]     neg;
    logic [2:0]     zero;
    logic [CW-1:0]  quarter;
  } side2_t;

  typedef struct packed {
    logic [3:0][CW-1:0] mag;
    logic [3:0]         neg;
  } side3_t;

  typedef struct packed {
    logic [3:0] neg;
    logic       ident;
  } side4_t;

  logic              en;
  logic [LAT-1:0]    vld_r;
  logic              out_valid_r;
  out_item_t         out_r;
  out_item_t         out_nxt;

  work_t             wk_d;
  logic [RW-1:0]     root1;
  side2_t            s2_in, s2_out;
  logic [2:0][NUM_WIDTH-1:0] numv;
  logic [2:0][NUM_WIDTH-1:0] numa;
  logic [2:0][K1-1:0]        quo1;

  logic [3:0][CW-1:0] am;
  logic [3:0]         an;
  logic [CW-1:0]      nm0, nm1, nm2;
  logic [2*CW-1:0]    sqr_r [4];
  side3_t             sq_side_r;
  logic [SW-1:0]      sum_r;
  side3_t             sum_side_r;

  logic [RW-1:0]      root2;
  side3_t             s3_out;
  side4_t             s4_in, s4_out;
  logic [3:0][K2-1:0] quo2;

  // the whole back end advances unless a finished item waits at the output
  assign en       = !out_valid_r || out_ready;
  assign wk_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], wk_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // s = 2 * isqrt(t * 2^F)
  rmq_isqrt #(.NW(T_WIDTH + F)) u_sqrt_s (
    .clk  (clk),
    .en   (en),
    .rad  ({wk_item.t, {F{1'b0}}}),
    .root (root1)
  );

  rmq_delay #(.W($bits(work_t)), .N(RW)) u_dly_work (
    .clk (clk),
    .en  (en),
    .d   (wk_item),
    .q   (wk_d)
  );

  assign numv = {wk_d.num0, wk_d.num1, wk_d.num2};

  for (genvar j = 0; j < 3; j++) begin : g_div_s
    assign numa[j]      = numv[j][NUM_WIDTH-1] ? -numv[j] : numv[j];
    assign s2_in.neg[j]  = numv[j][NUM_WIDTH-1];
    assign s2_in.zero[j] = numv[j] == '0;

    rmq_div #(.NW(NW1), .DNW(RW + 1), .K(K1)) u_div (
      .clk (clk),
      .en  (en),
      .num ({numa[j], {F{1'b0}}}),
      .den ({root1, 1'b0}),
      .quo (quo1[j])
    );
  end

  assign s2_in.tied    = wk_d.tied;
  assign s2_in.quarter = root1[RW-1:1];

  rmq_delay #(.W($bits(side2_t)), .N(K1 + 1)) u_dly_s2 (
    .clk (clk),
    .en  (en),
    .d   (s2_in),
    .q   (s2_out)
  );

  // numv is packed high to low, so num0 sits at index 2
  always_comb begin
    nm0 = s2_out.zero[2] ? '0 : quo1[2];
    nm1 = s2_out.zero[1] ? '0 : quo1[1];
    nm2 = s2_out.zero[0] ? '0 : quo1[0];
    case (s2_out.tied)
      TIED_W: begin
        am = {nm2, nm1, nm0, s2_out.quarter};
        an = {s2_out.neg[0], s2_out.neg[1], s2_out.neg[2], 1'b0};
      end
      TIED_X: begin
        am = {nm2, nm1, s2_out.quarter, nm0};
        an = {s2_out.neg[0], s2_out.neg[1], 1'b0, s2_out.neg[2]};
      end
      TIED_Y: begin
        am = {nm2, s2_out.quarter, nm1, nm0};
        an = {s2_out.neg[0], 1'b0, s2_out.neg[1], s2_out.neg[2]};
      end
      default: begin
        am = {s2_out.quarter, nm2, nm1, nm0};
        an = {1'b0, s2_out.neg[0], s2_out.neg[1], s2_out.neg[2]};
      end
    endcase
  end

  // square, then sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sqr_r[i] <= (2*CW)'(am[i]) * (2*CW)'(am[i]);
      end
      sq_side_r.mag <= am;
      sq_side_r.neg <= an;
      sum_r <= SW'(sqr_r[0]) + SW'(sqr_r[1]) + SW'(sqr_r[2]) + SW'(sqr_r[3]);
      sum_side_r <= sq_side_r;
    end
  end

  rmq_isqrt #(.NW(SW)) u_sqrt_mag (
    .clk  (clk),
    .en   (en),
    .rad  (sum_r),
    .root (root2)
  );

  rmq_delay #(.W($bits(side3_t)), .N(RW)) u_dly_s3 (
    .clk (clk),
    .en  (en),
    .d   (sum_side_r),
    .q   (s3_out)
  );

  assign s4_in.neg   = s3_out.neg;
  assign s4_in.ident = (root2 == '0) ||
                       (LW'({root2, {LIMIT_WIDTH{1'b0}}}) < LW'({limit, {F{1'b0}}}));

  for (genvar i = 0; i < 4; i++) begin : g_div_n
    rmq_div #(.NW(NW2), .DNW(RW), .K(K2)) u_div (
      .clk (clk),
      .en  (en),
      .num ({s3_out.mag[i], {F{1'b0}}}),
      .den (root2),
      .quo (quo2[i])
    );
  end

  rmq_delay #(.W($bits(side4_t)), .N(K2 + 1)) u_dly_s4 (
    .clk (clk),
    .en  (en),
    .d   (s4_in),
    .q   (s4_out)
  );

  function automatic logic [DATA_WIDTH-1:0] to_out(input logic [K2-1:0] quo,
                                                   input logic neg);
    logic [DATA_WIDTH-1:0] res;
    if (neg) begin
      if ((K2 + 1)'(quo) > ((K2 + 1)'(1) << (DATA_WIDTH - 1))) begin
        res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
        res = DATA_WIDTH'(-quo);
      end
    end else begin
      if (quo[K2-1]) begin
        res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
        res = DATA_WIDTH'(quo);
      end
    end
    return res;
  endfunction

  always_comb begin
    if (s4_out.ident) begin
      out_nxt.quat_w = DATA_WIDTH'(1) << F;
      out_nxt.quat_x = '0;
      out_nxt.quat_y = '0;
      out_nxt.quat_z = '0;
    end else begin
      out_nxt.quat_w = to_out(quo2[0], s4_out.neg[0]);
      out_nxt.quat_x = to_out(quo2[1], s4_out.neg[1]);
      out_nxt.quat_y = to_out(quo2[2], s4_out.neg[2]);
      out_nxt.quat_z = to_out(quo2[3], s4_out.neg[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// File: rtl/core/rotation_matrix_to_quaternion_top.sv
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top: rotation matrix to unit quaternion
// Shepperd branch selection, fixed-point root and divides, normalization.
// ---------------------------------------------------------------------------
// Takes one signed Q1.14 3x3 matrix per item and returns the normalized
// quaternion (w,x,y,z) in Q1.14; a magnitude of zero or below the limit
// register gives the identity. While no result is held at the output, one
// item enters per cycle and one result leaves per cycle. From acceptance to
// out_valid an item passes the branch select register, the queue and the
// 68 registers of the back end: the two bit-per-stage square roots
// (16 each), the component and normalize dividers (16 and 17 stages), the
// square and sum stages and the output register. A held result stalls the
// back end only; the front keeps taking items until its four-entry queue
// fills. cfg_ready is always high.
`default_nettype none

module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LIMIT_WIDTH-1:0] cfg_data
);

  logic [LIMIT_WIDTH-1:0] small_limit_r;
  logic                   fr_valid;
  logic                   fr_ready;
  work_t                  fr_item;
  logic                   q_valid;
  logic                   q_ready;
  work_t                  q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_limit_r <= LIMIT_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      small_limit_r <= cfg_data;
    end
  end

  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .wk_valid (fr_valid),
    .wk_ready (fr_ready),
    .wk_item  (fr_item)
  );

  rmq_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (fr_valid),
    .s_ready (fr_ready),
    .s_item  (fr_item),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_item  (q_item)
  );

  rmq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wk_valid  (q_valid),
    .wk_ready  (q_ready),
    .wk_item   (q_item),
    .limit     (small_limit_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: tb/sv/rmq_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rmq_checker: quaternion predictor and result scoreboard
// Watches the matrix, result and limit channels, computes the expected
// quaternion for every accepted matrix and compares each result in order.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_checker import rmq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_item,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [LIMIT_WIDTH-1:0] cfg_data,
  output int                     fail_count,
  output int                     pending_quats,
  output int                     quats_seen
);

  localparam longint ONE_Q    = longint'(1) << FRAC_BITS;
  localparam longint COMP_MAX = 2 * ONE_Q - 1;
  localparam longint OUT_MAX  = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint OUT_MIN  = -(longint'(1) << (DATA_WIDTH - 1));

  logic [LIMIT_WIDTH-1:0] mag_limit;
  out_item_t              quat_q[$];

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint div_by_s(longint num, longint s);
    if (s == 0) return num > 0 ? COMP_MAX : (num < 0 ? -COMP_MAX : 0);
    return sat((num * ONE_Q) / s, -COMP_MAX, COMP_MAX);
  endfunction

  function automatic out_item_t predict_quat(in_item_t mi, logic [LIMIT_WIDTH-1:0] lim);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint trace, t, r, s, quarter, mag, v;
    longint q[4];
    longint unsigned sumsq;
    tied_t tied;
    out_item_t res;
    a00 = mi.m00; a01 = mi.m01; a02 = mi.m02;
    a10 = mi.m10; a11 = mi.m11; a12 = mi.m12;
    a20 = mi.m20; a21 = mi.m21; a22 = mi.m22;
    trace = a00 + a11 + a22;
    if (trace > 0) begin
      tied = TIED_W; t = trace + ONE_Q;
    end else if (a00 > a11 && a00 > a22) begin
      tied = TIED_X; t = ONE_Q + a00 - a11 - a22;
    end else if (a11 > a22) begin
      tied = TIED_Y; t = ONE_Q + a11 - a00 - a22;
    end else begin
      tied = TIED_Z; t = ONE_Q + a22 - a00 - a11;
    end
    if (t < 0) t = 0;
    r = int_sqrt(longint'(t) << FRAC_BITS);
    s = 2 * r;
    quarter = sat(r >> 1, 0, COMP_MAX);
    case (tied)
      TIED_W: begin
        q[0] = quarter;                 q[1] = div_by_s(a21 - a12, s);
        q[2] = div_by_s(a02 - a20, s);  q[3] = div_by_s(a10 - a01, s);
      end
      TIED_X: begin
        q[0] = div_by_s(a21 - a12, s);  q[1] = quarter;
        q[2] = div_by_s(a10 + a01, s);  q[3] = div_by_s(a02 + a20, s);
      end
      TIED_Y: begin
        q[0] = div_by_s(a02 - a20, s);  q[1] = div_by_s(a10 + a01, s);
        q[2] = quarter;                 q[3] = div_by_s(a21 + a12, s);
      end
      default: begin
        q[0] = div_by_s(a10 - a01, s);  q[1] = div_by_s(a02 + a20, s);
        q[2] = div_by_s(a21 + a12, s);  q[3] = quarter;
      end
    endcase
    sumsq = 0;
    for (int i = 0; i < 4; i++) sumsq += longint'(q[i] * q[i]);
    mag = int_sqrt(sumsq);
    if (mag == 0 || (mag << 14) < (longint'(lim) << FRAC_BITS)) begin
      res.quat_w = DATA_WIDTH'(ONE_Q);
      res.quat_x = '0; res.quat_y = '0; res.quat_z = '0;
      return res;
    end
    for (int i = 0; i < 4; i++) begin
      v = sat((q[i] * ONE_Q) / mag, OUT_MIN, OUT_MAX);
      q[i] = v;
    end
    res.quat_w = DATA_WIDTH'(q[0]); res.quat_x = DATA_WIDTH'(q[1]);
    res.quat_y = DATA_WIDTH'(q[2]); res.quat_z = DATA_WIDTH'(q[3]);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
                                 logic [DATA_WIDTH-1:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mag_limit     <= 1;
      fail_count    = 0;
      pending_quats = 0;
      quats_seen    <= 0;
      quat_q.delete();
    end else begin
      // predict with the limit in force before any write in this cycle
      if (in_valid && in_ready) quat_q.push_back(predict_quat(in_item, mag_limit));
      if (cfg_valid && cfg_ready) mag_limit <= cfg_data;
      if (out_valid && out_ready) begin
        quats_seen <= quats_seen + 1;
        if (quat_q.size() == 0) begin
          report_mismatch("unexpected item", out_item.quat_w, '0);
        end else begin
          want = quat_q.pop_front();
          if (out_item.quat_w !== want.quat_w)
            report_mismatch("quat_w", out_item.quat_w, want.quat_w);
          if (out_item.quat_x !== want.quat_x)
            report_mismatch("quat_x", out_item.quat_x, want.quat_x);
          if (out_item.quat_y !== want.quat_y)
            report_mismatch("quat_y", out_item.quat_y, want.quat_y);
          if (out_item.quat_z !== want.quat_z)
            report_mismatch("quat_z", out_item.quat_z, want.quat_z);
        end
      end
      pending_quats = quat_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: matrix to quaternion testbench
// Directed corner matrices, then random rotations and noise under random
// stalls on both sides, across several magnitude limits.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import rmq_pkg::*;

  localparam int  RAND_ITEMS  = 1200;
  localparam int  LATENCY     = 80;
  localparam longint MAX_CYCLES = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [LIMIT_WIDTH-1:0] cfg_data = '0;
  int                     fail_count, pending_quats, quats_seen;
  longint                 cycle_count = 0;
  bit                     rx_idle_ok = 1'b1;
  bit                     rx_hold = 1'b0;
  int                     items_sent = 0;

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion_top u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
    .out_item, .cfg_valid, .cfg_ready, .cfg_data
  );

  rmq_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
    .out_item, .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending_quats,
    .quats_seen
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold that stalls the back end
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_idle_ok && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 11);
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_matrix(in_item_t mi, bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= mi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_and_set_limit(logic [LIMIT_WIDTH-1:0] lim);
    in_valid <= 1'b0;
    while (pending_quats != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_WIDTH-1:0] q14(real v);
    return DATA_WIDTH'($rtoi(v * 16384.0));
  endfunction

  // rotation from a random (unnormalized) quaternion, with optional jitter
  function automatic in_item_t random_rotation(int jitter);
    real a, b, c, d, n;
    real e[9];
    in_item_t mi;
    a = $itor($urandom_range(0, 2000)) - 1000.0;
    b = $itor($urandom_range(0, 2000)) - 1000.0;
    c = $itor($urandom_range(0, 2000)) - 1000.0;
    d = $itor($urandom_range(0, 2000)) - 1000.0;
    n = a*a + b*b + c*c + d*d;
    if (n == 0.0) begin a = 1.0; n = 1.0; end
    e[0] = 1.0 - 2.0*(c*c + d*d)/n; e[1] = 2.0*(b*c - a*d)/n; e[2] = 2.0*(b*d + a*c)/n;
    e[3] = 2.0*(b*c + a*d)/n; e[4] = 1.0 - 2.0*(b*b + d*d)/n; e[5] = 2.0*(c*d - a*b)/n;
    e[6] = 2.0*(b*d - a*c)/n; e[7] = 2.0*(c*d + a*b)/n; e[8] = 1.0 - 2.0*(b*b + c*c)/n;
    mi.m00 = q14(e[0]); mi.m01 = q14(e[1]); mi.m02 = q14(e[2]);
    mi.m10 = q14(e[3]); mi.m11 = q14(e[4]); mi.m12 = q14(e[5]);
    mi.m20 = q14(e[6]); mi.m21 = q14(e[7]); mi.m22 = q14(e[8]);
    if (jitter > 0) begin
      mi.m00 += $urandom_range(0, 2*jitter) - jitter;
      mi.m12 += $urandom_range(0, 2*jitter) - jitter;
      mi.m21 += $urandom_range(0, 2*jitter) - jitter;
    end
    return mi;
  endfunction

  function automatic in_item_t diag_matrix(int d0, int d1, int d2, int off);
    in_item_t mi;
    mi = '0;
    mi.m00 = DATA_WIDTH'(d0); mi.m11 = DATA_WIDTH'(d1); mi.m22 = DATA_WIDTH'(d2);
    mi.m01 = DATA_WIDTH'(off); mi.m10 = DATA_WIDTH'(-off);
    mi.m02 = DATA_WIDTH'(off); mi.m20 = DATA_WIDTH'(off);
    mi.m12 = DATA_WIDTH'(-off); mi.m21 = DATA_WIDTH'(off);
    return mi;
  endfunction

  task automatic run_random(int count, bit idle_ok);
    in_item_t mi;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6)       mi = random_rotation(0);
      else if (kind < 8)  mi = random_rotation(64);
      else                mi = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom,
                                                             $urandom, $urandom}));
      send_matrix(mi, idle_ok);
    end
  endtask

  initial begin
    in_item_t mi;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners: identity, each branch, extremes, zero matrix
    send_matrix(diag_matrix(16384, 16384, 16384, 0), 1'b0);
    send_matrix(diag_matrix(16384, -16384, -16384, 0), 1'b0);
    send_matrix(diag_matrix(-16384, 16384, -16384, 0), 1'b0);
    send_matrix(diag_matrix(-16384, -16384, 16384, 0), 1'b0);
    send_matrix(diag_matrix(0, 0, 0, 0), 1'b0);
    send_matrix(diag_matrix(-16384, -16384, -16384, 0), 1'b0);
    send_matrix(diag_matrix(-32768, -32768, -32768, 32767), 1'b0);
    send_matrix(diag_matrix(32767, 32767, 32767, -32768), 1'b0);
    send_matrix(diag_matrix(-32768, 32767, -32768, 32767), 1'b0);
    send_matrix(diag_matrix(-32768, -32768, 32767, -32768), 1'b0);
    send_matrix(diag_matrix(32767, -32768, -32768, 32767), 1'b0);
    send_matrix(diag_matrix(0, 0, 0, 1), 1'b0);
    send_matrix(diag_matrix(-10000, -10000, -10000, 1), 1'b0);
    mi = '1; send_matrix(mi, 1'b0);
    mi = '0; mi.m01 = 16'sh7fff; mi.m10 = 16'sh8000; send_matrix(mi, 1'b0);
    for (int i = 0; i < 6; i++) send_matrix(random_rotation(0), 1'b0);

    // hold the receiver so that the back end stalls while random items are sent
    rx_hold = 1'b1;
    fork
      begin repeat (200) @(negedge clk); rx_hold = 1'b0; end
      run_random(30, 1'b0);
    join

    drain_and_set_limit(14'h3fff);
    run_random(150, 1'b1);
    drain_and_set_limit(14'd0);
    run_random(150, 1'b1);
    drain_and_set_limit(14'd8192);
    run_random(150, 1'b1);
    drain_and_set_limit(14'd16283);
    run_random(150, 1'b1);
    drain_and_set_limit(14'd1);
    run_random(RAND_ITEMS - 750, 1'b1);

    // closing stretch without idling on either side
    rx_idle_ok = 1'b0;
    run_random(150, 1'b0);
    in_valid <= 1'b0;

    while (pending_quats != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    $display("Sent %0d matrices (corners, rotations, jittered and raw noise) under", items_sent);
    $display("five limit settings with stalls; %0d quaternions checked", quats_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
